// File: hdl/limited_event_counter_with_rate_assert.svh
// Assertion helpers shared by lecr_div and lecr_datapath; clock and reset are clk_i and rst_ni.
`ifndef LIMITED_EVENT_COUNTER_WITH_RATE_ASSERT_SVH
`define LIMITED_EVENT_COUNTER_WITH_RATE_ASSERT_SVH

// cons must hold in the same cycle as ante
`define LECR_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define LECR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lecr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lecr_pkg;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned CFG_IDX_W = 1;
  // bits needed to hold the rate scale of 1000
  localparam int unsigned RATE_SCALE_BITS = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_COUNT = 2'd0,
    CMD_SET   = 2'd1,
    CMD_TIME  = 2'd2,
    CMD_START = 2'd3
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_MODE = 1'b1;

  typedef struct packed {
    logic capture;
    logic apply;
    logic div_start;
    logic div_mean;
    logic rate_take;
    logic push;
    logic mean_zero;
    logic mean_take;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_time;
    logic needs_push;
    logic sample_zero;
    logic fill_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/lecr_div.sv
`timescale 1ns / 1ps
`default_nettype none

`include "limited_event_counter_with_rate_assert.svh"

// Restoring divider, one quotient bit per cycle. done_o pulses with quo_o valid.
module lecr_div #(
  parameter int unsigned NUM_W = 58,
  parameter int unsigned DEN_W = 48
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    step_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] dsr_q;
  logic [NUM_W-1:0] quo_q;

  logic [DEN_W:0]   shifted;
  logic             ge;
  logic [DEN_W:0]   diff;
  logic             last;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};
  assign last    = step_q == CW'(NUM_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  `LECR_ASSERT_HOLDS(a_div_start_idle, start_i, !busy_q, "divider restarted while busy")

endmodule

`default_nettype wire

// File: hdl/lecr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "limited_event_counter_with_rate_assert.svh"

module lecr_datapath #(
  parameter int unsigned WINDOW_DEPTH = 50,
  parameter int unsigned VALUE_BITS   = 48
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire lecr_pkg::ctrl_cmd_t              cmd_i,
  output lecr_pkg::dp_status_t                  status_o,
  input  wire logic [lecr_pkg::CMD_W-1:0]       in_command_i,
  input  wire logic [VALUE_BITS-1:0]            in_operand_i,
  input  wire logic                             cfg_valid_i,
  input  wire logic [lecr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [VALUE_BITS-1:0]            cfg_data_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic      [VALUE_BITS-1:0]            out_count_o,
  output logic                                  out_stopped_o,
  output logic      [VALUE_BITS-1:0]            out_mean_o
);

  localparam int unsigned HW = $clog2(WINDOW_DEPTH);
  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW = VALUE_BITS + $clog2(WINDOW_DEPTH);
  localparam int unsigned NW = VALUE_BITS + lecr_pkg::RATE_SCALE_BITS;

  lecr_pkg::cmd_e        cmd_q;
  logic [VALUE_BITS-1:0] opnd_q;

  logic [VALUE_BITS-1:0] cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] ref_q, ref_d;
  logic [VALUE_BITS-1:0] rtime_q, rtime_d;
  logic                  primed_q, primed_d;
  logic [HW-1:0]         head_q, head_d;
  logic [FW-1:0]         fill_q, fill_d;
  logic [SW-1:0]         sum_q, sum_d;
  logic [VALUE_BITS-1:0] mean_q, mean_d;
  logic [VALUE_BITS-1:0] limit_q;
  logic                  master_q;

  logic [NW-1:0]         num_q;
  logic [VALUE_BITS-1:0] den_q;
  logic [VALUE_BITS-1:0] sample_q;
  logic [VALUE_BITS-1:0] old_q;

  logic                  out_valid_q;
  logic [VALUE_BITS-1:0] out_cnt_q;
  logic                  out_stop_q;
  logic [VALUE_BITS-1:0] out_mean_q;

  logic [VALUE_BITS-1:0] win_mem [WINDOW_DEPTH];

  logic [VALUE_BITS-1:0] lim;
  logic                  inc_ok;
  logic                  full;
  logic                  t_newer;
  logic [NW-1:0]         delta_ext;
  logic [NW-1:0]         scaled;
  logic [NW-1:0]         div_num;
  logic [VALUE_BITS-1:0] div_den;
  logic [NW-1:0]         div_quo;
  logic                  div_done;
  logic [VALUE_BITS-1:0] rate_sat;

  assign lim     = master_q ? limit_q : '0;
  assign inc_ok  = ((lim == '0) || (cnt_q < lim)) && (cnt_q != '1);
  assign full    = fill_q == FW'(WINDOW_DEPTH);
  assign t_newer = (opnd_q != '0) && (rtime_q < opnd_q);

  // x1000 = x1024 - x16 - x8
  assign delta_ext = NW'(cnt_q - ref_q);
  assign scaled    = (delta_ext << 10) - (delta_ext << 4) - (delta_ext << 3);

  assign div_num = cmd_i.div_mean ? NW'(sum_q) : num_q;
  assign div_den = cmd_i.div_mean ? VALUE_BITS'(fill_q) : den_q;

  lecr_div #(
    .NUM_W (NW),
    .DEN_W (VALUE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign rate_sat = (div_quo[NW-1:VALUE_BITS] != '0) ? '1 : div_quo[VALUE_BITS-1:0];

  always_comb begin
    cnt_d    = cnt_q;
    ref_d    = ref_q;
    rtime_d  = rtime_q;
    primed_d = primed_q;
    head_d   = head_q;
    fill_d   = fill_q;
    sum_d    = sum_q;
    mean_d   = mean_q;
    if (cmd_i.apply) begin
      unique case (cmd_q)
        lecr_pkg::CMD_COUNT: begin
          if (inc_ok) cnt_d = cnt_q + 1'b1;
        end
        lecr_pkg::CMD_SET: begin
          cnt_d = opnd_q;
        end
        lecr_pkg::CMD_TIME: begin
          // time zero leaves the rate state alone
          if (opnd_q != '0) begin
            rtime_d = opnd_q;
            if (rtime_q < opnd_q) primed_d = 1'b1;
          end
        end
        lecr_pkg::CMD_START: begin
          cnt_d    = '0;
          ref_d    = '0;
          head_d   = '0;
          fill_d   = '0;
          sum_d    = '0;
          primed_d = 1'b0;
        end
      endcase
    end
    if (cmd_i.push) begin
      head_d = (head_q == HW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
      fill_d = full ? fill_q : fill_q + 1'b1;
      // the slot at head holds the oldest sample once the window is full
      sum_d  = sum_q + SW'(sample_q) - (full ? SW'(old_q) : '0);
      ref_d  = cnt_q;
    end
    if (cmd_i.mean_zero) mean_d = '0;
    if (cmd_i.mean_take) mean_d = div_quo[VALUE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ref_q       <= '0;
      rtime_q     <= '0;
      primed_q    <= 1'b0;
      head_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      limit_q     <= '0;
      master_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      ref_q    <= ref_d;
      rtime_q  <= rtime_d;
      primed_q <= primed_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      mean_q   <= mean_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          lecr_pkg::CFG_COUNT_LIMIT: limit_q  <= cfg_data_i;
          lecr_pkg::CFG_MASTER_MODE: master_q <= cfg_data_i[0];
        endcase
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= lecr_pkg::cmd_e'(in_command_i);
      opnd_q <= in_operand_i;
    end
    if (cmd_i.apply) begin
      num_q    <= scaled;
      den_q    <= opnd_q - rtime_q;
      sample_q <= '0;
    end
    if (cmd_i.rate_take) sample_q <= rate_sat;
    if (cmd_i.load_out) begin
      out_cnt_q  <= cnt_q;
      out_stop_q <= (lim != '0) && (cnt_q >= lim);
      out_mean_q <= mean_q;
    end
  end

  // window store: one write port, one registered read at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) win_mem[head_q] <= sample_q;
    old_q <= win_mem[head_q];
  end

  always_comb begin
    status_o.is_time     = cmd_q == lecr_pkg::CMD_TIME;
    status_o.needs_push  = t_newer && primed_q;
    status_o.sample_zero = (fill_q < FW'(2)) || (cnt_q < ref_q);
    status_o.fill_zero   = fill_q == '0;
    status_o.div_done    = div_done;
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign out_count_o   = out_cnt_q;
  assign out_stopped_o = out_stop_q;
  assign out_mean_o    = out_mean_q;

  `LECR_ASSERT_HOLDS(a_fill_range, 1'b1, fill_q <= FW'(WINDOW_DEPTH), "window fill out of range")
  `LECR_ASSERT_HOLDS(a_head_tracks_fill, !full, FW'(head_q) == fill_q,
                     "head and fill disagree before window is full")
  `LECR_ASSERT_NEXT(a_load_sets_valid, cmd_i.load_out, out_valid_q, "loaded result not valid")

endmodule

`default_nettype wire

// File: hdl/lecr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lecr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire lecr_pkg::dp_status_t status_i,
  output lecr_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RSTART,
    ST_RWAIT,
    ST_PUSH,
    ST_MSTART,
    ST_MWAIT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.capture = rdy_q && in_valid_i;
        if (rdy_q && in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.apply = 1'b1;
        priority if (!status_i.is_time)    state_d = ST_EMIT;
        else if (!status_i.needs_push)     state_d = ST_MSTART;
        else if (status_i.sample_zero)     state_d = ST_PUSH;
        else                               state_d = ST_RSTART;
      end
      ST_RSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (status_i.div_done) begin
          cmd_o.rate_take = 1'b1;
          state_d         = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_MSTART;
      end
      ST_MSTART: begin
        if (status_i.fill_zero) begin
          cmd_o.mean_zero = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_mean  = 1'b1;
          state_d         = ST_MWAIT;
        end
      end
      ST_MWAIT: begin
        if (status_i.div_done) begin
          cmd_o.mean_take = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdy_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rdy_q   <= state_d == ST_IDLE;
    end
  end

  assign in_ready_o = rdy_q;

endmodule

`default_nettype wire

// File: hdl/limited_event_counter_with_rate.sv
`timescale 1ns / 1ps
`default_nettype none

// Event counter with stop limit and windowed rate estimate. Each command on the
// input stream (tuser: 0 count, 1 set, 2 time update in ms, 3 start) yields one
// result: count, stopped flag and mean rate in events per second. A time update
// runs the sample division and the window-mean division through one shared
// divider that resolves one quotient bit per cycle. A time update that pushes no
// computed sample skips the first division. The result register lets the next item
// be taken while a result waits. Configuration writes are always ready and must be
// issued while idle.
module limited_event_counter_with_rate #(
  parameter int unsigned WINDOW_DEPTH = 50,
  parameter int unsigned VALUE_BITS   = 48
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [VALUE_BITS-1:0] operand
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // [1:0] command
  input  wire logic [lecr_pkg::CMD_W-1:0]     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [VALUE_BITS-1:0] count_value, [VALUE_BITS] stopped,
  // [2*VALUE_BITS:VALUE_BITS+1] mean_rate
  output logic [((2*VALUE_BITS+1+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lecr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [VALUE_BITS-1:0]          cfg_data_i
);

  localparam int unsigned OUT_W = ((2 * VALUE_BITS + 1 + 7) / 8) * 8;

  lecr_pkg::ctrl_cmd_t  cmd;
  lecr_pkg::dp_status_t status;

  logic [VALUE_BITS-1:0] out_count;
  logic                  out_stopped;
  logic [VALUE_BITS-1:0] out_mean;

  lecr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lecr_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .VALUE_BITS   (VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_command_i  (s_axis_tuser),
    .in_operand_i  (s_axis_tdata[VALUE_BITS-1:0]),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_count_o   (out_count),
    .out_stopped_o (out_stopped),
    .out_mean_o    (out_mean)
  );

  assign m_axis_tdata = OUT_W'({out_mean, out_stopped, out_count});
  assign cfg_ready_o  = 1'b1;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned VBITS          = 48;
  localparam int unsigned DEPTH          = 50;
  localparam int unsigned SETTLE_CYCLES  = 130;
  localparam int unsigned STALL_CYCLES   = 600;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic [VBITS-1:0] VMAX      = '1;

  typedef struct {
    logic [VBITS-1:0] count;
    logic             stopped;
    logic [VBITS-1:0] mean;
  } counter_result_t;

  logic clk;
  logic rst_n;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [VBITS-1:0] s_axis_tdata;     // [47:0] operand
  logic [lecr_pkg::CMD_W-1:0] s_axis_tuser;     // [1:0] command
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [103:0] m_axis_tdata;         // [47:0] count_value, [48] stopped, [96:49] mean_rate
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [lecr_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [VBITS-1:0] cfg_data_i;

  limited_event_counter_with_rate u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow of the counter state
  logic [VBITS-1:0] limit_reg;
  logic             master_reg;
  logic [VBITS-1:0] event_cnt;
  logic [VBITS-1:0] ref_cnt;
  logic [VBITS-1:0] last_rate_ms;
  bit               rate_armed;
  logic [VBITS-1:0] rate_win [DEPTH];
  int unsigned      win_head;
  int unsigned      win_fill;
  logic [VBITS-1:0] mean_rate;

  counter_result_t expected_results[$];
  counter_result_t got;
  int unsigned err_cnt;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned hold_request;
  logic [VBITS-1:0] now_ms;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // events per second, floored, saturating at the value width
  function automatic logic [VBITS-1:0] rate_of(logic [VBITS-1:0] delta,
                                               logic [VBITS-1:0] elapsed);
    logic [63:0] q;
    q = ({16'd0, delta} * 64'd1000) / {16'd0, elapsed};
    if (q > {16'd0, VMAX}) return VMAX;
    return q[VBITS-1:0];
  endfunction

  function automatic void time_update(logic [VBITS-1:0] t);
    logic [VBITS-1:0] s;
    if (t == 0) return;
    if (last_rate_ms >= t) begin
      last_rate_ms = t;
      return;
    end
    if (rate_armed) begin
      s = '0;
      if (win_fill >= 2 && event_cnt >= ref_cnt)
        s = rate_of(event_cnt - ref_cnt, t - last_rate_ms);
      rate_win[win_head] = s;
      win_head = (win_head + 1) % DEPTH;
      if (win_fill < DEPTH) win_fill++;
      ref_cnt = event_cnt;
    end
    last_rate_ms = t;
    rate_armed = 1'b1;
  endfunction

  function automatic logic [VBITS-1:0] window_mean();
    logic [63:0] sum;
    int unsigned first;
    if (win_fill == 0) return '0;
    sum = '0;
    first = (win_head + DEPTH - win_fill) % DEPTH;
    for (int unsigned i = 0; i < win_fill; i++)
      sum += {16'd0, rate_win[(first + i) % DEPTH]};
    sum = sum / 64'(win_fill);
    return sum[VBITS-1:0];
  endfunction

  function automatic counter_result_t predict_item(lecr_pkg::cmd_e cmd,
                                                   logic [VBITS-1:0] opnd);
    counter_result_t r;
    logic [VBITS-1:0] eff_lim;
    eff_lim = master_reg ? limit_reg : '0;
    case (cmd)
      lecr_pkg::CMD_COUNT: begin
        if ((eff_lim == 0 || event_cnt < eff_lim) && event_cnt < VMAX) event_cnt++;
      end
      lecr_pkg::CMD_SET: event_cnt = opnd;
      lecr_pkg::CMD_TIME: begin
        time_update(opnd);
        mean_rate = window_mean();
      end
      default: begin
        event_cnt  = '0;
        ref_cnt    = '0;
        win_head   = 0;
        win_fill   = 0;
        rate_armed = 1'b0;
      end
    endcase
    r.count   = event_cnt;
    r.stopped = (eff_lim != 0 && event_cnt >= eff_lim);
    r.mean    = mean_rate;
    return r;
  endfunction

  function automatic void check_field(string name, logic [VBITS-1:0] exp_v,
                                      logic [VBITS-1:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none actual %h", $time, m_axis_tdata);
      end else begin
        got = expected_results.pop_front();
        check_field("count_value", got.count, m_axis_tdata[47:0]);
        check_field("stopped", {47'd0, got.stopped}, {47'd0, m_axis_tdata[48]});
        check_field("mean_rate", got.mean, m_axis_tdata[96:49]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stretches of random stall behavior, plus a long hold-off on request
  initial begin
    int unsigned stretch_left;
    int unsigned mode;
    int unsigned hold_left;
    stretch_left = 0;
    mode = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (stretch_left == 0) begin
        mode = $urandom_range(0, 3);
        stretch_left = $urandom_range(20, 300);
      end
      stretch_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 9) < 3);
          default: m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  task automatic send_item(input lecr_pkg::cmd_e cmd, input logic [VBITS-1:0] opnd);
    int unsigned gap;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= opnd;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(predict_item(cmd, opnd));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(0, 15);
    end
  endtask

  task automatic write_reg(input logic [lecr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [VBITS-1:0] value);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk); while (!cfg_ready_o);
    if (idx == lecr_pkg::CFG_COUNT_LIMIT) limit_reg = value;
    else master_reg = value[0];
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly counts and rising time stamps so the window fills with real samples
  task automatic random_item();
    int unsigned pick;
    int unsigned sub;
    logic [VBITS-1:0] op;
    op = VBITS'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      send_item(lecr_pkg::CMD_COUNT, op);
    end else if (pick < 83) begin
      sub = $urandom_range(0, 19);
      if (sub < 10) now_ms = now_ms + VBITS'($urandom_range(1, 3000));
      else if (sub < 14) now_ms = now_ms + VBITS'($urandom_range(1, 3));
      else if (sub < 15) now_ms = now_ms + VBITS'(op[31:0]);
      else if (sub < 17) now_ms = now_ms - VBITS'($urandom_range(0, 50));
      else if (sub < 19) now_ms = op;
      if (sub == 19) send_item(lecr_pkg::CMD_TIME, '0);
      else send_item(lecr_pkg::CMD_TIME, now_ms);
    end else if (pick < 97) begin
      sub = $urandom_range(0, 9);
      if (sub < 3) op = VBITS'($urandom_range(0, 400));
      else if (sub < 5) op = VMAX - VBITS'($urandom_range(0, 3));
      else if (sub < 6) op = event_cnt - VBITS'($urandom_range(1, 20));
      send_item(lecr_pkg::CMD_SET, op);
    end else begin
      send_item(lecr_pkg::CMD_START, op);
    end
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) random_item();
  endtask

  task automatic test_directed();
    write_reg(lecr_pkg::CFG_COUNT_LIMIT, '0);
    write_reg(lecr_pkg::CFG_MASTER_MODE, 48'd0);
    send_item(lecr_pkg::CMD_COUNT, '0);
    send_item(lecr_pkg::CMD_TIME, '0);          // zero time only refreshes the mean
    send_item(lecr_pkg::CMD_TIME, 48'd100);     // arms the rate
    send_item(lecr_pkg::CMD_COUNT, VMAX);
    send_item(lecr_pkg::CMD_COUNT, VMAX);
    send_item(lecr_pkg::CMD_TIME, 48'd200);     // empty window, sample forced to zero
    send_item(lecr_pkg::CMD_COUNT, '0);
    send_item(lecr_pkg::CMD_TIME, 48'd300);     // one sample held, still zero
    repeat (3) send_item(lecr_pkg::CMD_COUNT, '0);
    send_item(lecr_pkg::CMD_TIME, 48'd301);     // first real sample
    send_item(lecr_pkg::CMD_TIME, 48'd250);     // older stamp just rewinds
    send_item(lecr_pkg::CMD_SET, VMAX - 48'd1);
    send_item(lecr_pkg::CMD_COUNT, '0);
    send_item(lecr_pkg::CMD_COUNT, '0);         // holds at the top
    send_item(lecr_pkg::CMD_TIME, 48'd251);     // huge delta over 1 ms saturates
    send_item(lecr_pkg::CMD_SET, 48'd5);
    send_item(lecr_pkg::CMD_TIME, 48'd400);     // count fell, sample zero
    send_item(lecr_pkg::CMD_START, VMAX);
    send_item(lecr_pkg::CMD_TIME, 48'd500);
    drain();
  endtask

  task automatic test_limit_directed();
    write_reg(lecr_pkg::CFG_MASTER_MODE, 48'd1);
    write_reg(lecr_pkg::CFG_COUNT_LIMIT, 48'd3);
    repeat (4) send_item(lecr_pkg::CMD_COUNT, '0);
    send_item(lecr_pkg::CMD_SET, 48'd10);       // above the limit is allowed
    send_item(lecr_pkg::CMD_COUNT, '0);
    send_item(lecr_pkg::CMD_SET, '0);
    drain();
  endtask

  task automatic test_random_unlimited();
    write_reg(lecr_pkg::CFG_COUNT_LIMIT, VBITS'({$urandom, $urandom}) | 48'd1);
    write_reg(lecr_pkg::CFG_MASTER_MODE, 48'd0);
    run_random(450);
    drain();
  endtask

  task automatic test_random_limited();
    write_reg(lecr_pkg::CFG_MASTER_MODE, 48'd1);
    write_reg(lecr_pkg::CFG_COUNT_LIMIT, VBITS'($urandom_range(1, 300)));
    run_random(450);
    drain();
  endtask

  task automatic test_limit_at_top();
    write_reg(lecr_pkg::CFG_COUNT_LIMIT, VMAX);
    run_random(500);
    drain();
  endtask

  // result side held off while items keep coming, so the input has to stall
  task automatic test_output_stall();
    write_reg(lecr_pkg::CFG_COUNT_LIMIT, 48'd1);
    write_reg(lecr_pkg::CFG_MASTER_MODE, 48'd0);
    hold_request = STALL_CYCLES;
    burst_left = 100;
    repeat (60) begin
      if ($urandom_range(0, 3) == 0) begin
        now_ms = now_ms + VBITS'($urandom_range(1, 500));
        send_item(lecr_pkg::CMD_TIME, now_ms);
      end else begin
        send_item(lecr_pkg::CMD_COUNT, '0);
      end
    end
    run_random(300);
    drain();
  endtask

  initial begin
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = lecr_pkg::CMD_COUNT;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = lecr_pkg::CFG_COUNT_LIMIT;
    cfg_data_i    = '0;
    limit_reg     = '0;
    master_reg    = 1'b0;
    event_cnt     = '0;
    ref_cnt       = '0;
    last_rate_ms  = '0;
    rate_armed    = 1'b0;
    win_head      = 0;
    win_fill      = 0;
    mean_rate     = '0;
    err_cnt       = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    hold_request  = 0;
    now_ms        = 48'd1000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_limit_directed();
    test_random_unlimited();
    test_random_limited();
    test_limit_at_top();
    test_output_stall();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
